// ===== src/bbwq_pkg.sv =====
package bbwq_pkg;

  localparam int PID_BITS = 8;
  localparam int TAG_BITS = 16;
  localparam int CFG_BITS = 5;
  localparam int DATA_DEPTH_DEF = 16;
  localparam int WAIT_DEPTH_DEF = 16;
  localparam logic [CFG_BITS-1:0] BUF_SIZE_RESET = 5'd16;

  localparam logic KIND_PROD = 1'b0;
  localparam logic KIND_CONS = 1'b1;

  localparam logic [1:0] OUTCOME_DONE = 2'd0;
  localparam logic [1:0] OUTCOME_BLOCKED = 2'd1;
  localparam logic [1:0] OUTCOME_REJECTED = 2'd2;

  typedef struct packed {
    logic                mode;
    logic [PID_BITS-1:0] pid;
    logic [TAG_BITS-1:0] product_tag;
  } in_item_t;

  typedef struct packed {
    logic [PID_BITS-1:0] run_pid;
    logic                run_kind;
    logic [1:0]          outcome;
    logic [TAG_BITS-1:0] item_tag;
    logic                last;
  } out_item_t;

  typedef struct packed {
    logic load_in;
    logic exec;
    logic may_wake;
  } cmd_t;

  typedef struct packed {
    logic out_last;
  } sts_t;

endpackage

// ===== src/bbwq_ctrl.sv =====
module bbwq_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  bbwq_pkg::sts_t  sts,
  output bbwq_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_OUT  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   second_r, second_nxt;

  always_comb begin
    state_nxt   = state_r;
    second_nxt  = second_r;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd         = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          second_nxt  = 1'b0;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec     = 1'b1;
        cmd.may_wake = !second_r;
        state_nxt    = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.out_last) begin
            in_ready = 1'b1;
            if (in_valid) begin
              cmd.load_in = 1'b1;
              second_nxt  = 1'b0;
              state_nxt   = ST_EXEC;
            end else begin
              state_nxt = ST_IDLE;
            end
          end else begin
            second_nxt = 1'b1;
            state_nxt  = ST_EXEC;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      second_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      second_r <= second_nxt;
    end
  end

endmodule

// ===== src/bbwq_dp.sv =====
module bbwq_dp #(
  parameter int DATA_DEPTH = bbwq_pkg::DATA_DEPTH_DEF,
  parameter int WAIT_DEPTH = bbwq_pkg::WAIT_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bbwq_pkg::in_item_t                in_data,
  input  logic                              cfg_we,
  input  logic [bbwq_pkg::CFG_BITS-1:0]     cfg_data,
  input  bbwq_pkg::cmd_t                    cmd,
  output bbwq_pkg::sts_t                    sts,
  output bbwq_pkg::out_item_t               out_data
);

  localparam int PW = bbwq_pkg::PID_BITS;
  localparam int TW = bbwq_pkg::TAG_BITS;
  localparam int DAW = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
  localparam int DCW = $clog2(DATA_DEPTH + 1);
  localparam int WAW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int WCW = $clog2(WAIT_DEPTH + 1);
  localparam int CMPW = (DCW > bbwq_pkg::CFG_BITS) ? DCW : bbwq_pkg::CFG_BITS;

  logic [TW-1:0]    data_mem [DATA_DEPTH];
  logic [PW+TW-1:0] pw_mem   [WAIT_DEPTH];
  logic [PW-1:0]    cw_mem   [WAIT_DEPTH];

  logic [TW-1:0]    data_rd_r;
  logic [PW+TW-1:0] pw_rd_r;
  logic [PW-1:0]    cw_rd_r;

  bbwq_pkg::in_item_t  item_r, item_nxt;
  bbwq_pkg::out_item_t out_r, out_nxt;
  logic [bbwq_pkg::CFG_BITS-1:0] buf_size_r, buf_size_nxt;
  logic [DAW-1:0] data_head_r, data_head_nxt;
  logic [DCW-1:0] data_cnt_r, data_cnt_nxt;
  logic [WAW-1:0] pw_head_r, pw_head_nxt, cw_head_r, cw_head_nxt;
  logic [WCW-1:0] pw_cnt_r, pw_cnt_nxt, cw_cnt_r, cw_cnt_nxt;

  logic [DAW:0]   data_sum, data_tail_full;
  logic [WAW:0]   pw_sum, pw_tail_full, cw_sum, cw_tail_full;
  logic [DAW-1:0] data_tail, data_head_inc;
  logic [WAW-1:0] pw_tail, cw_tail, pw_head_inc, cw_head_inc;
  logic           data_full;

  logic             data_we, pw_we, cw_we;
  logic [TW-1:0]    data_wdata;
  logic [PW+TW-1:0] pw_wdata;
  logic [PW-1:0]    cw_wdata;

  always_comb begin
    data_sum       = {1'b0, data_head_r} + (DAW+1)'(data_cnt_r);
    data_tail_full = (data_sum >= (DAW+1)'(DATA_DEPTH)) ?
                     data_sum - (DAW+1)'(DATA_DEPTH) : data_sum;
    data_tail      = data_tail_full[DAW-1:0];
    pw_sum         = {1'b0, pw_head_r} + (WAW+1)'(pw_cnt_r);
    pw_tail_full   = (pw_sum >= (WAW+1)'(WAIT_DEPTH)) ?
                     pw_sum - (WAW+1)'(WAIT_DEPTH) : pw_sum;
    pw_tail        = pw_tail_full[WAW-1:0];
    cw_sum         = {1'b0, cw_head_r} + (WAW+1)'(cw_cnt_r);
    cw_tail_full   = (cw_sum >= (WAW+1)'(WAIT_DEPTH)) ?
                     cw_sum - (WAW+1)'(WAIT_DEPTH) : cw_sum;
    cw_tail        = cw_tail_full[WAW-1:0];
    data_head_inc  = (data_head_r == DAW'(DATA_DEPTH - 1)) ? '0 : data_head_r + DAW'(1);
    pw_head_inc    = (pw_head_r == WAW'(WAIT_DEPTH - 1)) ? '0 : pw_head_r + WAW'(1);
    cw_head_inc    = (cw_head_r == WAW'(WAIT_DEPTH - 1)) ? '0 : cw_head_r + WAW'(1);
    data_full      = (CMPW'(data_cnt_r) >= CMPW'(buf_size_r)) ||
                     (data_cnt_r == DCW'(DATA_DEPTH));
  end

  always_comb begin
    item_nxt      = item_r;
    out_nxt       = out_r;
    buf_size_nxt  = buf_size_r;
    data_head_nxt = data_head_r;
    data_cnt_nxt  = data_cnt_r;
    pw_head_nxt   = pw_head_r;
    pw_cnt_nxt    = pw_cnt_r;
    cw_head_nxt   = cw_head_r;
    cw_cnt_nxt    = cw_cnt_r;
    data_we       = 1'b0;
    pw_we         = 1'b0;
    cw_we         = 1'b0;
    data_wdata    = item_r.product_tag;
    pw_wdata      = {item_r.pid, item_r.product_tag};
    cw_wdata      = item_r.pid;

    if (cfg_we) begin
      buf_size_nxt = cfg_data;
    end
    if (cmd.load_in) begin
      item_nxt = in_data;
    end

    if (cmd.exec) begin
      out_nxt.run_pid  = item_r.pid;
      out_nxt.run_kind = item_r.mode;
      out_nxt.outcome  = bbwq_pkg::OUTCOME_DONE;
      out_nxt.item_tag = '0;
      out_nxt.last     = 1'b1;
      if (item_r.mode == bbwq_pkg::KIND_PROD) begin
        if (data_full) begin
          if (pw_cnt_r == WCW'(WAIT_DEPTH)) begin
            out_nxt.outcome = bbwq_pkg::OUTCOME_REJECTED;
          end else begin
            pw_we           = 1'b1;
            pw_cnt_nxt      = pw_cnt_r + WCW'(1);
            out_nxt.outcome = bbwq_pkg::OUTCOME_BLOCKED;
          end
        end else begin
          data_we          = 1'b1;
          data_cnt_nxt     = data_cnt_r + DCW'(1);
          out_nxt.item_tag = item_r.product_tag;
          if (cmd.may_wake && (cw_cnt_r != '0)) begin
            item_nxt.mode        = bbwq_pkg::KIND_CONS;
            item_nxt.pid         = cw_rd_r;
            item_nxt.product_tag = '0;
            cw_head_nxt          = cw_head_inc;
            cw_cnt_nxt           = cw_cnt_r - WCW'(1);
            out_nxt.last         = 1'b0;
          end
        end
      end else begin
        if (data_cnt_r == '0) begin
          if (cw_cnt_r == WCW'(WAIT_DEPTH)) begin
            out_nxt.outcome = bbwq_pkg::OUTCOME_REJECTED;
          end else begin
            cw_we           = 1'b1;
            cw_cnt_nxt      = cw_cnt_r + WCW'(1);
            out_nxt.outcome = bbwq_pkg::OUTCOME_BLOCKED;
          end
        end else begin
          out_nxt.item_tag = data_rd_r;
          data_head_nxt    = data_head_inc;
          data_cnt_nxt     = data_cnt_r - DCW'(1);
          if (cmd.may_wake && (pw_cnt_r != '0)) begin
            item_nxt.mode        = bbwq_pkg::KIND_PROD;
            item_nxt.pid         = pw_rd_r[PW+TW-1:TW];
            item_nxt.product_tag = pw_rd_r[TW-1:0];
            pw_head_nxt          = pw_head_inc;
            pw_cnt_nxt           = pw_cnt_r - WCW'(1);
            out_nxt.last         = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (data_we) begin
      data_mem[data_tail] <= data_wdata;
    end
    data_rd_r <= data_mem[data_head_r];
  end

  always_ff @(posedge clk) begin
    if (pw_we) begin
      pw_mem[pw_tail] <= pw_wdata;
    end
    pw_rd_r <= pw_mem[pw_head_r];
  end

  always_ff @(posedge clk) begin
    if (cw_we) begin
      cw_mem[cw_tail] <= cw_wdata;
    end
    cw_rd_r <= cw_mem[cw_head_r];
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    out_r  <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_size_r  <= bbwq_pkg::BUF_SIZE_RESET;
      data_head_r <= '0;
      data_cnt_r  <= '0;
      pw_head_r   <= '0;
      pw_cnt_r    <= '0;
      cw_head_r   <= '0;
      cw_cnt_r    <= '0;
    end else begin
      buf_size_r  <= buf_size_nxt;
      data_head_r <= data_head_nxt;
      data_cnt_r  <= data_cnt_nxt;
      pw_head_r   <= pw_head_nxt;
      pw_cnt_r    <= pw_cnt_nxt;
      cw_head_r   <= cw_head_nxt;
      cw_cnt_r    <= cw_cnt_nxt;
    end
  end

  assign sts.out_last = out_r.last;
  assign out_data     = out_r;

endmodule

// ===== src/bounded_buffer_with_wait_queues.sv =====
// After an item is accepted it passes through the execute state, and its first result is
// registered and offered in the result-hold state, which holds it until out_ready. Each run
// of a process passes through both states; an item that wakes a waiter has a second run for it.
// The next item is taken in the same cycle that the final result of an item is taken.
// Reset (synchronous, active low) empties all three queues, sets buffer_size to 16
// and needs no clearing pass; the queue memories are not cleared.
module bounded_buffer_with_wait_queues #(
  parameter int DATA_DEPTH = bbwq_pkg::DATA_DEPTH_DEF,
  parameter int WAIT_DEPTH = bbwq_pkg::WAIT_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  bbwq_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output bbwq_pkg::out_item_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bbwq_pkg::CFG_BITS-1:0] cfg_data
);

  bbwq_pkg::cmd_t cmd;
  bbwq_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  bbwq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bbwq_dp #(
    .DATA_DEPTH (DATA_DEPTH),
    .WAIT_DEPTH (WAIT_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cfg_we   (cfg_valid),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule
